// File: rtl/core/tld_pkg.sv
`default_nettype none
package tld_pkg;

  // line store geometry
  localparam int unsigned LINE_DEPTH = 32;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned LEN_W      = $clog2(LINE_DEPTH + 1);

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // config register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_EOL    = 3'd1;
  localparam logic [2:0] REG_EOF    = 3'd2;
  localparam logic [2:0] REG_ERASE  = 3'd3;
  localparam logic [2:0] REG_HELD   = 3'd4;

  // mode_flags bit positions
  localparam int unsigned MODE_IGN_CR     = 0;
  localparam int unsigned MODE_CR_TO_EOL  = 1;
  localparam int unsigned MODE_EOL_TO_CR  = 2;
  localparam int unsigned MODE_ECHO       = 3;
  localparam int unsigned MODE_ECHO_CTL   = 4;
  localparam int unsigned MODE_ECHO_ERASE = 5;
  localparam int unsigned MODE_CANON      = 6;

  // result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SP      = 8'd32;
  localparam logic [7:0] CH_CARET   = 8'd94;
  localparam logic [7:0] CTL_LIMIT  = 8'd32;
  localparam logic [7:0] CTL_OFFSET = 8'd64;

  // up to three echo bytes ahead of any read data
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] b;
  } echo_t;

  // what one received byte does
  typedef struct packed {
    echo_t      echo;
    logic       rel;        // drain the line store
    logic       tail_en;    // one closing result
    logic [1:0] tail_kind;
    logic [7:0] tail_byte;
    logic       store;      // append chr to the line
    logic       erase;      // drop last stored byte
    logic [7:0] chr;
  } plan_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } ram_rd_t;

endpackage
`default_nettype wire

// File: rtl/core/tld_ram.sv
`default_nettype none
module tld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tld_decode.sv
`default_nettype none
module tld_decode (
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic [6:0]       mode_i,
  input  wire logic [7:0]       eol_i,
  input  wire logic [7:0]       eof_i,
  input  wire logic [7:0]       erase_i,
  input  wire logic [31:0]      held_i,
  input  wire tld_pkg::len_t    len_i,
  output tld_pkg::plan_t        plan_o
);

  function automatic tld_pkg::echo_t echo_of(logic [7:0] c, logic [6:0] mode,
                                              logic [7:0] eol);
    tld_pkg::echo_t e;
    e = '0;
    if (mode[tld_pkg::MODE_ECHO]) begin
      if (c != tld_pkg::CH_NUL && c < tld_pkg::CTL_LIMIT && c != eol &&
          c != tld_pkg::CH_TAB) begin
        if (mode[tld_pkg::MODE_ECHO_CTL]) begin
          e.cnt  = 2'd2;
          e.b[0] = tld_pkg::CH_CARET;
          e.b[1] = c + tld_pkg::CTL_OFFSET;
        end
      end else begin
        e.cnt  = 2'd1;
        e.b[0] = c;
      end
    end
    return e;
  endfunction

  logic       is_cr;
  logic [7:0] c;
  logic       held;
  logic       empty;
  logic       full;

  assign is_cr = (rx_byte_i == tld_pkg::CH_CR);
  assign empty = (len_i == '0);
  assign full  = (len_i >= tld_pkg::len_t'(tld_pkg::LINE_DEPTH));
  assign held  = (c < tld_pkg::CTL_LIMIT) && (c != tld_pkg::CH_TAB) && held_i[c[4:0]];

  // CR / end-of-line mapping
  always_comb begin
    if (is_cr && mode_i[tld_pkg::MODE_CR_TO_EOL]) begin
      c = eol_i;
    end else if (rx_byte_i == eol_i && mode_i[tld_pkg::MODE_EOL_TO_CR]) begin
      c = tld_pkg::CH_CR;
    end else begin
      c = rx_byte_i;
    end
  end

  always_comb begin
    plan_o     = '0;
    plan_o.chr = c;
    priority if (is_cr && mode_i[tld_pkg::MODE_IGN_CR]) begin
      // dropped, no results
    end else if (!mode_i[tld_pkg::MODE_CANON]) begin
      plan_o.echo      = echo_of(c, mode_i, eol_i);
      plan_o.tail_en   = 1'b1;
      plan_o.tail_kind = tld_pkg::KIND_READ;
      plan_o.tail_byte = c;
    end else if (c == eol_i) begin
      plan_o.echo      = echo_of(c, mode_i, eol_i);
      plan_o.rel       = 1'b1;
      plan_o.tail_en   = 1'b1;
      plan_o.tail_kind = tld_pkg::KIND_READ;
      plan_o.tail_byte = c;
    end else if (c == eof_i) begin
      if (empty) begin
        plan_o.tail_en   = 1'b1;
        plan_o.tail_kind = tld_pkg::KIND_EOF;
        plan_o.tail_byte = tld_pkg::CH_NUL;
      end else begin
        plan_o.rel = 1'b1;
      end
    end else if (c == erase_i) begin
      if (!empty) begin
        plan_o.erase = 1'b1;
        if (mode_i[tld_pkg::MODE_ECHO_ERASE]) begin
          plan_o.echo.cnt  = 2'd3;
          plan_o.echo.b[0] = tld_pkg::CH_BS;
          plan_o.echo.b[1] = tld_pkg::CH_SP;
          plan_o.echo.b[2] = tld_pkg::CH_BS;
        end else begin
          plan_o.echo = echo_of(c, mode_i, eol_i);
        end
      end
    end else if (!held && !full) begin
      plan_o.store = 1'b1;
      plan_o.echo  = echo_of(c, mode_i, eol_i);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tld_emit.sv
`default_nettype none
module tld_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tld_pkg::plan_t    plan_i,
  input  wire tld_pkg::len_t     len_i,
  output logic                   idle_o,
  output tld_pkg::ram_rd_t       rd_o,
  input  wire logic [7:0]        rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             out_kind_o,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ECHO = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [1:0]     state_q, state_d;
  tld_pkg::len_t  idx_q, idx_d;
  tld_pkg::plan_t plan_q;
  tld_pkg::len_t  rel_len_q;
  logic           valid_q;
  logic [1:0]     kind_q, kind_d;
  logic [7:0]     byte_q, byte_d;
  logic           last_q, last_d;

  logic           adv;
  tld_pkg::len_t  idx_inc;
  tld_pkg::len_t  limit;
  logic           hit;
  logic           more_rel;
  logic           start_rel;

  // one counter, one incrementer, one compare: shared by echo and drain phases
  assign adv      = (state_q != S_IDLE) && (!valid_q || out_ready_i);
  assign idx_inc  = idx_q + 1'b1;
  assign limit    = (state_q == S_REL) ? rel_len_q
                                       : {{(tld_pkg::LEN_W-2){1'b0}}, plan_q.echo.cnt};
  assign hit      = (idx_inc == limit);
  assign more_rel = plan_q.rel && (rel_len_q != '0);
  assign start_rel = plan_i.rel && (len_i != '0);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    kind_d  = tld_pkg::KIND_ECHO;
    byte_d  = plan_q.echo.b[idx_q[1:0]];
    last_d  = 1'b0;
    rd_o    = '0;
    if (start_i) begin
      idx_d      = '0;
      rd_o.en    = 1'b1;
      rd_o.addr  = '0;
      if (plan_i.echo.cnt != 2'd0) begin
        state_d = S_ECHO;
      end else if (start_rel) begin
        state_d = S_REL;
      end else if (plan_i.tail_en) begin
        state_d = S_TAIL;
      end else begin
        state_d = S_IDLE;
      end
    end else if (adv) begin
      unique case (state_q)
        S_ECHO: begin
          kind_d = tld_pkg::KIND_ECHO;
          byte_d = plan_q.echo.b[idx_q[1:0]];
          last_d = hit && !more_rel && !plan_q.tail_en;
          if (hit) begin
            idx_d = '0;
            if (more_rel) begin
              state_d = S_REL;
            end else if (plan_q.tail_en) begin
              state_d = S_TAIL;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            idx_d = idx_inc;
          end
        end
        S_REL: begin
          kind_d = tld_pkg::KIND_READ;
          byte_d = rdata_i;
          last_d = hit && !plan_q.tail_en;
          if (hit) begin
            idx_d   = '0;
            state_d = plan_q.tail_en ? S_TAIL : S_IDLE;
          end else begin
            idx_d     = idx_inc;
            rd_o.en   = 1'b1;
            rd_o.addr = idx_inc[tld_pkg::ADDR_W-1:0];
          end
        end
        S_TAIL: begin
          kind_d  = plan_q.tail_kind;
          byte_d  = plan_q.tail_byte;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (adv) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      plan_q    <= plan_i;
      rel_len_q <= len_i;
    end
    if (adv) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("tld_emit: start while busy");

  a_rel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REL |-> (rel_len_q != '0) && (idx_q < rel_len_q))
    else $error("tld_emit: drain index out of range");

  a_echo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ECHO |-> idx_q < {{(tld_pkg::LEN_W-2){1'b0}}, plan_q.echo.cnt})
    else $error("tld_emit: echo index out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_d) |=> state_q == S_IDLE)
    else $error("tld_emit: result marked last but sequence continues");

endmodule
`default_nettype wire

// File: rtl/core/tty_line_discipline.sv
`default_nettype none
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] out_byte, tuser[1:0] out_kind,
//                                              tlast last
// cfg       in   cfg_we_i (no back-pressure)   cfg_idx_i register, cfg_data_i value
//
// An accepted byte is decoded in the accept cycle, then its results leave one per cycle
// from a single output register while m_axis_tready allows: up to 3 echo bytes, up to
// LINE_DEPTH stored bytes, one closing result. Worst case 34 results at full drain. The
// result sequencer walks echo and line store with one shared counter and the store's
// single read port.
// s_axis_tready is high only while the sequencer is idle; a held result in the output
// register does not block the next accept. Reset empties the line; no clearing pass.
module tty_line_discipline (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received characters
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // echo and reader stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
  output logic             m_axis_tlast,
  // register writes
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [6:0]        mode_q;
  logic [7:0]        eol_q;
  logic [7:0]        eof_q;
  logic [7:0]        erase_q;
  logic [31:0]       held_q;
  tld_pkg::len_t     line_len_q, line_len_d;

  tld_pkg::plan_t    plan;
  tld_pkg::ram_rd_t  rd;
  logic [7:0]        rdata;
  logic              idle;
  logic              accept;

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 7'd120;
      eol_q   <= 8'd10;
      eof_q   <= 8'd4;
      erase_q <= 8'd127;
      held_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tld_pkg::REG_MODE:  mode_q  <= cfg_data_i[6:0];
        tld_pkg::REG_EOL:   eol_q   <= cfg_data_i[7:0];
        tld_pkg::REG_EOF:   eof_q   <= cfg_data_i[7:0];
        tld_pkg::REG_ERASE: erase_q <= cfg_data_i[7:0];
        tld_pkg::REG_HELD:  held_q  <= cfg_data_i;
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  tld_decode u_decode (
    .rx_byte_i (s_axis_tdata),
    .mode_i    (mode_q),
    .eol_i     (eol_q),
    .eof_i     (eof_q),
    .erase_i   (erase_q),
    .held_i    (held_q),
    .len_i     (line_len_q),
    .plan_o    (plan)
  );

  // line fill level: drain empties it, store appends, erase backs off one
  always_comb begin
    line_len_d = line_len_q;
    if (accept) begin
      priority if (plan.rel) begin
        line_len_d = '0;
      end else if (plan.store) begin
        line_len_d = line_len_q + 1'b1;
      end else if (plan.erase) begin
        line_len_d = line_len_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
    end else begin
      line_len_q <= line_len_d;
    end
  end

  tld_ram #(
    .WIDTH (8),
    .DEPTH (tld_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && plan.store),
    .waddr_i (line_len_q[tld_pkg::ADDR_W-1:0]),
    .wdata_i (plan.chr),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  tld_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .plan_i      (plan),
    .len_i       (line_len_q),
    .idle_o      (idle),
    .rd_o        (rd),
    .rdata_i     (rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_len_q <= tld_pkg::len_t'(tld_pkg::LINE_DEPTH))
    else $error("tty_line_discipline: line length beyond store depth");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && plan.store) |-> line_len_q < tld_pkg::len_t'(tld_pkg::LINE_DEPTH))
    else $error("tty_line_discipline: store into full line");

endmodule
`default_nettype wire
